>>> sv/pgb_pkg.sv
// ----------------------------------------------------------------------------
// pgb_pkg
// Shared types and constants of the particle grid binner.
// ----------------------------------------------------------------------------
package pgb_pkg;

  localparam int GRID_COLS     = 64;
  localparam int GRID_ROWS     = 64;
  localparam int CELL_SLOTS    = 16;
  localparam int GRID_CELLS    = GRID_COLS * GRID_ROWS;

  localparam int CELL_AW  = $clog2(GRID_CELLS);
  localparam int SLOT_AW  = $clog2(CELL_SLOTS);
  localparam int LIST_AW  = CELL_AW + SLOT_AW;

  localparam int POS_W     = 20;
  localparam int GRP_W     = 4;
  localparam int PIDX_W    = 10;
  localparam int CIDX_W    = 12;
  localparam int SLOT_W    = 4;
  localparam int CX_W      = 6;
  localparam int CZ_W      = 6;
  localparam int CELLID_W  = 12;
  localparam int CNT_W     = 5;
  localparam int OCC_W     = 5;

  localparam int ORIGIN_W   = 20;
  localparam int INV_W      = 24;
  localparam int STRIDE_W   = 7;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  localparam int DIFF_W     = POS_W + 1;
  localparam int FRAC_W     = 24;
  localparam int PROD_W     = POS_W + INV_W;
  localparam int ID_FULL_W  = CZ_W + STRIDE_W + 1;

  localparam logic [OCC_W-1:0] OCC_MIXED = OCC_W'(16);
  localparam logic [OCC_W-1:0] OCC_EMPTY = OCC_W'(17);

  localparam logic [ORIGIN_W-1:0] ORIGIN_RST = '0;
  localparam logic [INV_W-1:0]    INV_RST    = INV_W'(65536);
  localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(64);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OFF_GRID = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 2'd0,
    REG_ORIGIN_Z   = 2'd1,
    REG_INV_CELL   = 2'd2,
    REG_ROW_STRIDE = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_ID,
    S_RD,
    S_WB,
    S_CLR,
    S_FIN
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_z;
    logic [GRP_W-1:0]   grp;
    logic [PIDX_W-1:0]  particle_index;
    logic [CIDX_W-1:0]  cell_index;
    logic [SLOT_W-1:0]  slot;
  } in_beat_t;

  typedef struct packed {
    logic [CX_W-1:0]     cell_x;
    logic [CZ_W-1:0]     cell_z;
    logic [CELLID_W-1:0] cell_id;
    logic [CNT_W-1:0]    count;
    logic [PIDX_W-1:0]   entry;
    logic                entry_valid;
    logic [OCC_W-1:0]    occupancy;
    status_e             status;
  } out_beat_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [OCC_W-1:0] occupancy;
  } cell_ent_t;

endpackage

>>> sv/particle_grid_binner_top.sv
// ----------------------------------------------------------------------------
// particle_grid_binner_top
// Bins particles into a uniform 2-D grid and reads back cell contents.
// ----------------------------------------------------------------------------
// The block works on one beat at a time. An insert steps through offset,
// multiply, cell id, memory read, and write back with output; an off-grid
// insert leaves the memory untouched. A clear, and the reset, walk the
// count/occupancy memory one cell per cycle, and after reset no beat is
// accepted until that sweep is done; configuration writes are taken at all
// times. The steps follow the read-modify-write of the shared
// count/occupancy memory. A finished result waits in the output register
// while the next beat enters.
module particle_grid_binner_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pgb_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [pgb_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  pgb_pkg::in_beat_t                     in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output pgb_pkg::out_beat_t                    out_data_o
);

  logic signed [pgb_pkg::ORIGIN_W-1:0] origin_x_q, origin_z_q;
  logic [pgb_pkg::INV_W-1:0]           inv_q;
  logic [pgb_pkg::STRIDE_W-1:0]        stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= pgb_pkg::ORIGIN_RST;
      origin_z_q <= pgb_pkg::ORIGIN_RST;
      inv_q      <= pgb_pkg::INV_RST;
      stride_q   <= pgb_pkg::STRIDE_RST;
    end else if (cfg_we_i) begin
      case (pgb_pkg::cfg_reg_e'(cfg_idx_i))
        pgb_pkg::REG_ORIGIN_X:   origin_x_q <= cfg_wdata_i[pgb_pkg::ORIGIN_W-1:0];
        pgb_pkg::REG_ORIGIN_Z:   origin_z_q <= cfg_wdata_i[pgb_pkg::ORIGIN_W-1:0];
        pgb_pkg::REG_INV_CELL:   inv_q      <= cfg_wdata_i[pgb_pkg::INV_W-1:0];
        pgb_pkg::REG_ROW_STRIDE: stride_q   <= cfg_wdata_i[pgb_pkg::STRIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pgb_pkg::state_e                  state_q, state_d;
  logic [pgb_pkg::CELL_AW-1:0]      clr_cnt_q, clr_cnt_d;
  logic                             clr_emit_q, clr_emit_d;
  logic                             out_valid_q;
  pgb_pkg::out_beat_t               out_q, out_d;
  logic                             out_load;
  logic                             out_free;

  pgb_pkg::in_beat_t                item_q;
  logic signed [pgb_pkg::DIFF_W-1:0] dx_q, dz_q;
  logic                             neg_q;
  logic [pgb_pkg::PROD_W-1:0]       prod_x_q, prod_z_q;
  logic [pgb_pkg::CX_W-1:0]         cx_q;
  logic [pgb_pkg::CZ_W-1:0]         cz_q;
  logic [pgb_pkg::ID_FULL_W-1:0]    id_q;
  logic                             off_q;

  logic [pgb_pkg::PROD_W-pgb_pkg::FRAC_W-1:0] cx_full, cz_full;
  logic                             id_off;
  logic                             cidx_off;

  pgb_pkg::cell_ent_t               cell_mem [pgb_pkg::GRID_CELLS];
  pgb_pkg::cell_ent_t               cell_rd_q;
  pgb_pkg::cell_ent_t               cell_wdata;
  logic [pgb_pkg::CELL_AW-1:0]      cell_raddr, cell_waddr;
  logic                             cell_re, cell_we;

  logic [pgb_pkg::PIDX_W-1:0]       list_mem [2**pgb_pkg::LIST_AW];
  logic [pgb_pkg::PIDX_W-1:0]       list_rd_q;
  logic [pgb_pkg::LIST_AW-1:0]      list_raddr, list_waddr;
  logic                             list_re, list_we;

  logic                             cell_full;
  logic [pgb_pkg::OCC_W-1:0]        occ_new;
  logic                             slot_hit;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign cx_full  = prod_x_q[pgb_pkg::PROD_W-1:pgb_pkg::FRAC_W];
  assign cz_full  = prod_z_q[pgb_pkg::PROD_W-1:pgb_pkg::FRAC_W];
  assign id_off   = 32'(id_q) >= 32'(pgb_pkg::GRID_CELLS);
  assign cidx_off = 32'(item_q.cell_index) >= 32'(pgb_pkg::GRID_CELLS);

  assign cell_raddr = (item_q.op == pgb_pkg::OP_READ) ?
                      item_q.cell_index[pgb_pkg::CELL_AW-1:0] :
                      id_q[pgb_pkg::CELL_AW-1:0];
  assign list_raddr = {item_q.cell_index[pgb_pkg::CELL_AW-1:0],
                       item_q.slot[pgb_pkg::SLOT_AW-1:0]};
  assign list_waddr = {id_q[pgb_pkg::CELL_AW-1:0],
                       cell_rd_q.count[pgb_pkg::SLOT_AW-1:0]};

  assign cell_full = cell_rd_q.count >= pgb_pkg::CNT_W'(pgb_pkg::CELL_SLOTS);
  assign occ_new   = (cell_rd_q.occupancy == pgb_pkg::OCC_EMPTY ||
                      cell_rd_q.occupancy == pgb_pkg::OCC_W'(item_q.grp)) ?
                     pgb_pkg::OCC_W'(item_q.grp) : pgb_pkg::OCC_MIXED;
  assign slot_hit  = pgb_pkg::CNT_W'(item_q.slot) < cell_rd_q.count;

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    clr_emit_d = clr_emit_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    out_d      = '0;
    out_d.occupancy = pgb_pkg::OCC_EMPTY;
    out_d.status    = pgb_pkg::ST_OK;
    cell_re    = 1'b0;
    cell_we    = 1'b0;
    cell_waddr = id_q[pgb_pkg::CELL_AW-1:0];
    cell_wdata.count     = cell_rd_q.count + pgb_pkg::CNT_W'(1);
    cell_wdata.occupancy = occ_new;
    list_re    = 1'b0;
    list_we    = 1'b0;
    case (state_q)
      pgb_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_data_i.op)
            pgb_pkg::OP_INSERT: state_d = pgb_pkg::S_DIFF;
            pgb_pkg::OP_READ:   state_d = pgb_pkg::S_RD;
            pgb_pkg::OP_CLEAR: begin
              state_d    = pgb_pkg::S_CLR;
              clr_cnt_d  = '0;
              clr_emit_d = 1'b1;
            end
            default:            state_d = pgb_pkg::S_FIN;
          endcase
        end
      end
      pgb_pkg::S_DIFF: state_d = pgb_pkg::S_MUL;
      pgb_pkg::S_MUL:  state_d = pgb_pkg::S_ID;
      pgb_pkg::S_ID:   state_d = pgb_pkg::S_RD;
      pgb_pkg::S_RD: begin
        if (item_q.op == pgb_pkg::OP_READ) begin
          if (cidx_off) begin
            state_d = pgb_pkg::S_FIN;
          end else begin
            cell_re = 1'b1;
            list_re = 1'b1;
            state_d = pgb_pkg::S_WB;
          end
        end else if (off_q || id_off) begin
          state_d = pgb_pkg::S_FIN;
        end else begin
          cell_re = 1'b1;
          state_d = pgb_pkg::S_WB;
        end
      end
      pgb_pkg::S_WB: begin
        if (item_q.op == pgb_pkg::OP_READ) begin
          out_d.cell_id     = pgb_pkg::CELLID_W'(item_q.cell_index);
          out_d.count       = cell_rd_q.count;
          out_d.occupancy   = cell_rd_q.occupancy;
          out_d.entry_valid = slot_hit;
          out_d.entry       = slot_hit ? list_rd_q : '0;
        end else begin
          out_d.cell_x  = cx_q;
          out_d.cell_z  = cz_q;
          out_d.cell_id = pgb_pkg::CELLID_W'(id_q);
          if (cell_full) begin
            out_d.count     = cell_rd_q.count;
            out_d.occupancy = cell_rd_q.occupancy;
            out_d.status    = pgb_pkg::ST_FULL;
          end else begin
            out_d.count     = cell_wdata.count;
            out_d.occupancy = occ_new;
          end
        end
        if (out_free) begin
          out_load = 1'b1;
          state_d  = pgb_pkg::S_IDLE;
          if (item_q.op == pgb_pkg::OP_INSERT && !cell_full) begin
            cell_we = 1'b1;
            list_we = 1'b1;
          end
        end
      end
      pgb_pkg::S_CLR: begin
        cell_we              = 1'b1;
        cell_waddr           = clr_cnt_q;
        cell_wdata.count     = '0;
        cell_wdata.occupancy = pgb_pkg::OCC_EMPTY;
        if (clr_cnt_q == pgb_pkg::CELL_AW'(pgb_pkg::GRID_CELLS - 1)) begin
          state_d = clr_emit_q ? pgb_pkg::S_FIN : pgb_pkg::S_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + pgb_pkg::CELL_AW'(1);
        end
      end
      pgb_pkg::S_FIN: begin
        if (item_q.op == pgb_pkg::OP_READ) begin
          out_d.cell_id = pgb_pkg::CELLID_W'(item_q.cell_index);
          out_d.status  = pgb_pkg::ST_OFF_GRID;
        end else if (item_q.op == pgb_pkg::OP_INSERT) begin
          out_d.status  = pgb_pkg::ST_OFF_GRID;
        end
        if (out_free) begin
          out_load = 1'b1;
          state_d  = pgb_pkg::S_IDLE;
        end
      end
      default: state_d = pgb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pgb_pkg::S_CLR;
      clr_cnt_q   <= '0;
      clr_emit_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      clr_emit_q <= clr_emit_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (state_q == pgb_pkg::S_DIFF) begin
      dx_q  <= pgb_pkg::DIFF_W'(signed'(item_q.pos_x)) - pgb_pkg::DIFF_W'(origin_x_q);
      dz_q  <= pgb_pkg::DIFF_W'(signed'(item_q.pos_z)) - pgb_pkg::DIFF_W'(origin_z_q);
    end
    if (state_q == pgb_pkg::S_MUL) begin
      neg_q    <= dx_q[pgb_pkg::DIFF_W-1] || dz_q[pgb_pkg::DIFF_W-1];
      prod_x_q <= dx_q[pgb_pkg::POS_W-1:0] * inv_q;
      prod_z_q <= dz_q[pgb_pkg::POS_W-1:0] * inv_q;
    end
    if (state_q == pgb_pkg::S_ID) begin
      off_q <= neg_q ||
               32'(cx_full) >= 32'(pgb_pkg::GRID_COLS) ||
               32'(cz_full) >= 32'(pgb_pkg::GRID_ROWS);
      cx_q  <= cx_full[pgb_pkg::CX_W-1:0];
      cz_q  <= cz_full[pgb_pkg::CZ_W-1:0];
      id_q  <= pgb_pkg::ID_FULL_W'(cz_full[pgb_pkg::CZ_W-1:0]) *
               pgb_pkg::ID_FULL_W'(stride_q) +
               pgb_pkg::ID_FULL_W'(cx_full[pgb_pkg::CX_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rd_q <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_waddr] <= item_q.particle_index;
    end
    if (list_re) begin
      list_rd_q <= list_mem[list_raddr];
    end
  end

`ifndef ASSERT_OFF
  a_list_with_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    list_we |-> cell_we && cell_wdata.count <= pgb_pkg::CNT_W'(pgb_pkg::CELL_SLOTS))
    else $error("list write without a matching count update");

  a_read_issues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.op == pgb_pkg::OP_READ) |=>
    (cell_re || state_q == pgb_pkg::S_FIN))
    else $error("accepted read beat did not reach the memory");

  a_sweep_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pgb_pkg::S_CLR |->
    cell_we && cell_wdata.occupancy == pgb_pkg::OCC_EMPTY && !in_ready_o)
    else $error("clear sweep wrote a non-empty cell or took a beat");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result overwrote a pending output beat");
`endif

endmodule

>>> tb/sv/particle_grid_binner_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_grid_binner_top_tb
// Self-checking bench for the particle grid binner. A queue of clear, insert,
// read and no-op beats feeds a driver with random gaps, and a monitor with
// random stalls compares each result with a shadow grid kept in the bench.
// Runs go through several origin, cell size and row stride settings.
// ----------------------------------------------------------------------------
module particle_grid_binner_top_tb;
  import pgb_pkg::*;

  localparam int     MAX_GAP         = 13;
  localparam int     RESET_CYCLES    = 6;
  localparam int     SETTLE_CYCLES   = 8;
  localparam int     HOT_CELLS       = 3;
  localparam int     ITEMS_PER_PHASE = 186;
  localparam int     PRESSURE_AT     = 400;
  localparam int     PRESSURE_LEN    = 600;
  localparam int     WATCHDOG_LIMIT  = 25000;
  localparam int     MAX_SHOWN       = 10;
  localparam longint POS_MAX         = 524287;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_beat_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_beat_t             out_data_o;

  particle_grid_binner_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  in_beat_t  particle_beats_q[$];
  out_beat_t grid_reports_due[$];

  logic [CNT_W-1:0]  cell_fill  [GRID_CELLS];
  logic [OCC_W-1:0]  cell_occ   [GRID_CELLS];
  logic [PIDX_W-1:0] cell_slots [GRID_CELLS*CELL_SLOTS];

  longint org_x    = 0;
  longint org_z    = 0;
  longint inv_size = longint'(INV_RST);
  longint row_len  = longint'(STRIDE_RST);

  logic [POS_W-1:0]  hot_px  [HOT_CELLS];
  logic [POS_W-1:0]  hot_pz  [HOT_CELLS];
  logic [GRP_W-1:0]  hot_grp [HOT_CELLS];
  logic [CIDX_W-1:0] hot_id  [HOT_CELLS];

  int report_errors = 0;
  int reports_seen  = 0;
  int send_gap      = 0;
  int recv_gap      = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;
  bit send_burst    = 1'b0;
  bit recv_burst    = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void queue_beat(in_beat_t b);
    particle_beats_q.insert(particle_beats_q.size(), b);
  endfunction

  function automatic void clear_shadow_grid();
    for (int i = 0; i < GRID_CELLS; i++) begin
      cell_fill[i] = '0;
      cell_occ[i]  = OCC_EMPTY;
    end
  endfunction

  function automatic out_beat_t bin_and_report(in_beat_t b);
    out_beat_t r;
    longint    dx, dz, cx, cz, id;
    int        cnt, cid;
    r           = '0;
    r.occupancy = OCC_EMPTY;
    r.status    = ST_OK;
    case (b.op)
      OP_INSERT: begin
        dx = longint'($signed(b.pos_x)) - org_x;
        dz = longint'($signed(b.pos_z)) - org_z;
        if (dx < 0 || dz < 0) begin
          r.status = ST_OFF_GRID;
        end else begin
          cx = (dx * inv_size) >> FRAC_W;
          cz = (dz * inv_size) >> FRAC_W;
          id = cz * row_len + cx;
          if (cx >= GRID_COLS || cz >= GRID_ROWS || id >= GRID_CELLS) begin
            r.status = ST_OFF_GRID;
          end else begin
            r.cell_x  = cx[CX_W-1:0];
            r.cell_z  = cz[CZ_W-1:0];
            r.cell_id = id[CELLID_W-1:0];
            cnt = cell_fill[id];
            if (cnt >= CELL_SLOTS) begin
              r.count     = cell_fill[id];
              r.occupancy = cell_occ[id];
              r.status    = ST_FULL;
            end else begin
              cell_slots[id*CELL_SLOTS + cnt] = b.particle_index;
              cell_fill[id] = CNT_W'(cnt + 1);
              if (cell_occ[id] == OCC_EMPTY || cell_occ[id] == {1'b0, b.grp}) begin
                cell_occ[id] = {1'b0, b.grp};
              end else begin
                cell_occ[id] = OCC_MIXED;
              end
              r.count     = cell_fill[id];
              r.occupancy = cell_occ[id];
            end
          end
        end
      end
      OP_READ: begin
        cid = b.cell_index;
        r.cell_id = b.cell_index;
        if (cid >= GRID_CELLS) begin
          r.status = ST_OFF_GRID;
        end else begin
          r.count     = cell_fill[cid];
          r.occupancy = cell_occ[cid];
          if (b.slot < cell_fill[cid]) begin
            r.entry_valid = 1'b1;
            r.entry       = cell_slots[cid*CELL_SLOTS + b.slot];
          end
        end
      end
      OP_CLEAR: begin
        clear_shadow_grid();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void check_cell_report(out_beat_t got);
    out_beat_t want;
    if (grid_reports_due.size() == 0) begin
      report_errors++;
      if (report_errors <= MAX_SHOWN)
        $display("unexpected result beat: id=%0d cnt=%0d occ=%0d st=%0d",
                 got.cell_id, got.count, got.occupancy, got.status);
    end else begin
      want = grid_reports_due.pop_front();
      if (got.cell_x !== want.cell_x || got.cell_z !== want.cell_z ||
          got.cell_id !== want.cell_id || got.count !== want.count ||
          got.entry !== want.entry || got.entry_valid !== want.entry_valid ||
          got.occupancy !== want.occupancy || got.status !== want.status) begin
        report_errors++;
        if (report_errors <= MAX_SHOWN) begin
          $display("result %0d expected: x=%0d z=%0d id=%0d cnt=%0d ent=%0d ev=%0b occ=%0d st=%0d",
                   reports_seen, want.cell_x, want.cell_z, want.cell_id, want.count,
                   want.entry, want.entry_valid, want.occupancy, want.status);
          $display("result %0d actual:   x=%0d z=%0d id=%0d cnt=%0d ent=%0d ev=%0b occ=%0d st=%0d",
                   reports_seen, got.cell_x, got.cell_z, got.cell_id, got.count,
                   got.entry, got.entry_valid, got.occupancy, got.status);
        end
      end
    end
  endfunction

  // Position at the smallest offset from the origin that lands in column or row c.
  function automatic longint pos_of_cell(int c, longint org);
    longint d;
    d = ((longint'(c) << FRAC_W) + inv_size - 1) / inv_size;
    return org + d;
  endfunction

  function automatic void pick_hot_cells();
    int     cx, cz;
    longint px, pz;
    for (int k = 0; k < HOT_CELLS; k++) begin
      cx = (k == 0) ? $urandom_range(0, 3) : $urandom_range(0, GRID_COLS-1);
      cz = (k == 0) ? $urandom_range(0, 3) : $urandom_range(0, GRID_ROWS-1);
      px = pos_of_cell(cx, org_x);
      pz = pos_of_cell(cz, org_z);
      hot_px[k]  = (px <= POS_MAX) ? px[POS_W-1:0] : POS_W'($urandom);
      hot_pz[k]  = (pz <= POS_MAX) ? pz[POS_W-1:0] : POS_W'($urandom);
      hot_id[k]  = CIDX_W'(longint'(cz) * row_len + cx);
      hot_grp[k] = GRP_W'($urandom);
    end
  endfunction

  function automatic in_beat_t beat_of(op_e op, int px, int pz, int grp, int pidx,
                                       int cidx, int sl);
    in_beat_t b;
    b.op             = op;
    b.pos_x          = POS_W'(px);
    b.pos_z          = POS_W'(pz);
    b.grp            = GRP_W'(grp);
    b.particle_index = PIDX_W'(pidx);
    b.cell_index     = CIDX_W'(cidx);
    b.slot           = SLOT_W'(sl);
    return b;
  endfunction

  function automatic in_beat_t random_particle_beat();
    in_beat_t b;
    int       pick, k;
    longint   px, pz;
    b.op             = OP_NOP;
    b.pos_x          = POS_W'($urandom);
    b.pos_z          = POS_W'($urandom);
    b.grp            = GRP_W'($urandom);
    b.particle_index = PIDX_W'($urandom);
    b.cell_index     = CIDX_W'($urandom);
    b.slot           = SLOT_W'($urandom);
    pick = $urandom_range(0, 199);
    k    = $urandom_range(0, HOT_CELLS-1);
    if (pick < 2) begin
      b.op = OP_CLEAR;
    end else if (pick < 112) begin
      b.op = OP_INSERT;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        b.pos_x = hot_px[k];
        b.pos_z = hot_pz[k];
        if (k == 0 || $urandom_range(0, 4) != 0) b.grp = hot_grp[k];
      end else if (pick < 85) begin
        px = pos_of_cell($urandom_range(0, GRID_COLS-1), org_x) + $urandom_range(0, 3);
        pz = pos_of_cell($urandom_range(0, GRID_ROWS-1), org_z) + $urandom_range(0, 3);
        if (px <= POS_MAX) b.pos_x = px[POS_W-1:0];
        if (pz <= POS_MAX) b.pos_z = pz[POS_W-1:0];
      end
    end else if (pick < 182) begin
      b.op = OP_READ;
      if ($urandom_range(0, 9) < 6) b.cell_index = hot_id[k];
    end
    return b;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_ORIGIN_X:   org_x    = longint'($signed(val[ORIGIN_W-1:0]));
      REG_ORIGIN_Z:   org_z    = longint'($signed(val[ORIGIN_W-1:0]));
      REG_INV_CELL:   inv_size = longint'(val[INV_W-1:0]);
      REG_ROW_STRIDE: row_len  = longint'(val[STRIDE_W-1:0]);
      default: begin
      end
    endcase
  endtask

  task automatic program_grid(int ox, int oz, int inv, int stride);
    write_reg(REG_ORIGIN_X, CFG_DATA_W'(ORIGIN_W'(ox)));
    write_reg(REG_ORIGIN_Z, CFG_DATA_W'(ORIGIN_W'(oz)));
    write_reg(REG_INV_CELL, CFG_DATA_W'(inv));
    write_reg(REG_ROW_STRIDE, CFG_DATA_W'(stride));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_grid();
    while (particle_beats_q.size() != 0 || in_valid_i || grid_reports_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        grid_reports_due.insert(grid_reports_due.size(), bin_and_report(in_data_i));
        if ($urandom_range(0, 24) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (particle_beats_q.size() > 0) begin
          in_data_i  <= particle_beats_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        check_cell_report(out_data_o);
        reports_seen++;
        if ($urandom_range(0, 24) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (reports_seen == PRESSURE_AT) hold_left = PRESSURE_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    clear_shadow_grid();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default settings: one cell per 256 position steps, 64 cells per row.
    queue_beat(beat_of(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    queue_beat(beat_of(OP_NOP, 0, 0, 0, 0, 0, 0));
    queue_beat(beat_of(OP_INSERT, 0, 0, 3, 0, 0, 0));
    queue_beat(beat_of(OP_INSERT, 255, 255, 3, 1023, 0, 0));
    queue_beat(beat_of(OP_INSERT, 0, 0, 9, 5, 0, 0));
    queue_beat(beat_of(OP_INSERT, 16383, 16383, 15, 512, 0, 0));
    queue_beat(beat_of(OP_INSERT, -1, 0, 1, 1, 0, 0));
    queue_beat(beat_of(OP_INSERT, 0, -524288, 1, 2, 0, 0));
    queue_beat(beat_of(OP_INSERT, 524287, 524287, 1, 3, 0, 0));
    queue_beat(beat_of(OP_INSERT, 16384, 0, 1, 4, 0, 0));
    queue_beat(beat_of(OP_INSERT, 0, 16384, 1, 6, 0, 0));
    queue_beat(beat_of(OP_READ, 0, 0, 0, 0, 0, 0));
    queue_beat(beat_of(OP_READ, 0, 0, 0, 0, 0, 2));
    queue_beat(beat_of(OP_READ, 0, 0, 0, 0, 0, 3));
    queue_beat(beat_of(OP_READ, 0, 0, 0, 0, 0, 15));
    queue_beat(beat_of(OP_READ, 0, 0, 0, 0, 4095, 0));
    queue_beat(beat_of(OP_READ, 0, 0, 0, 0, 1, 0));
    queue_beat(beat_of(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    queue_beat(beat_of(OP_READ, 0, 0, 0, 0, 0, 0));
    queue_beat(beat_of(OP_NOP, 0, 0, 0, 0, 0, 0));
    queue_beat(beat_of(OP_INSERT, 256, 512, 0, 7, 0, 0));
    drain_grid();

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: program_grid(-524288, -524288, 16777215, 64);
        2: program_grid(524287, 524287, 1, 1);
        3: program_grid($urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096,
                        $urandom_range(1024, 262144), $urandom_range(1, 64));
        4: program_grid(0, 0, 65536, 127);
        default: program_grid($urandom_range(0, 1048575) - 524288,
                              $urandom_range(0, 1048575) - 524288,
                              $urandom_range(1, 16777215), $urandom_range(1, 64));
      endcase
      pick_hot_cells();
      if (ph == 4) begin
        // Row stride above the grid width pushes the cell id past the last cell.
        queue_beat(beat_of(OP_INSERT, 0, 16128, 2, 11, 0, 0));
        queue_beat(beat_of(OP_INSERT, 16128, 8192, 2, 12, 0, 0));
        queue_beat(beat_of(OP_INSERT, 1280, 512, 2, 13, 0, 0));
        queue_beat(beat_of(OP_READ, 0, 0, 0, 0, 259, 0));
      end
      repeat (ITEMS_PER_PHASE) queue_beat(random_particle_beat());
      drain_grid();
    end

    if (report_errors == 0 && grid_reports_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
